/* rtl/bse_pkg.sv */
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, constants and the symbol mapping for the Base92 stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

   // bit buffer and block geometry
   localparam int BUF_BITS    = 20;
   localparam int CNT_BITS    = 5;
   localparam int BLOCK_BITS  = 13;
   localparam int SHORT_BITS  = 6;
   localparam int CHAR_BITS   = 7;
   localparam int QUOT_BITS   = 7;

   // divide by 91 as multiply by reciprocal: floor(v * 2881 / 2^18) for v < 8192
   localparam int RADIX       = 91;
   localparam int RECIP       = 2881;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_BITS   = 25;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_BITS-1:0] TILDE_CHAR = 7'd126;

   typedef enum logic [0:0] {
      JOB_PAIR,
      JOB_SINGLE
   } job_kind_type;

   typedef enum logic [0:0] {
      PH_HIGH,
      PH_LOW
   } phase_type;

   // one unit of work: a 13-bit block (two chars) or one finished char
   typedef struct packed {
      job_kind_type            kind;
      logic [BLOCK_BITS-1:0]   value;
      logic                    end_of_run;
      logic                    end_of_message;
   } job_type;

   // map a symbol index 0..90 onto the printable alphabet
   function automatic logic [CHAR_BITS-1:0] sym_code(input logic [CHAR_BITS-1:0] v);
      logic [CHAR_BITS-1:0] ch;
      if (v == 7'd0) begin
         ch = 7'd33;
      end else if (v < 7'd62) begin
         ch = v + 7'd34;
      end else begin
         ch = v + 7'd35;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

/* rtl/bse_front.sv */
// ----------------------------------------------------------------------------
// bse_front
// Accepts message bytes, keeps the bit buffer and turns each byte into zero,
// one or two jobs for the character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_front import bse_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   input  wire logic                 req_empty_message,
   output logic                      job_push,
   output job_type                   job_data,
   input  wire logic                 job_full
);

   logic [BUF_BITS-1:0]   buffer_ff, buffer_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pend_valid_ff, pend_valid_in;
   job_type               pend_job_ff, pend_job_in;

   logic                  accept;
   logic [BUF_BITS-1:0]   buf_new;
   logic [CNT_BITS-1:0]   cnt8;
   logic [CNT_BITS-1:0]   cnt_left;
   logic                  has_block;
   logic                  has_flush;
   logic [2:0]            blk_shift;
   logic [BUF_BITS-1:0]   blk_shifted;
   logic [3:0]            pair_shift;
   logic [BLOCK_BITS-1:0] pair_value;
   logic [2:0]            short_shift;
   logic [SHORT_BITS-1:0] short_value;
   job_type               block_job;
   job_type               flush_job;
   job_type               first_job;

   assign full   = pend_valid_ff | job_full;
   assign accept = push & ~full;

   // shift the byte in and find the block and the flush leftovers
   always_comb begin
      buf_new     = {buffer_ff[BUF_BITS-9:0], req_data_byte};
      cnt8        = count_ff + CNT_BITS'(8);
      has_block   = cnt8 >= CNT_BITS'(BLOCK_BITS);
      blk_shift   = 3'(cnt8 - CNT_BITS'(BLOCK_BITS));
      blk_shifted = buf_new >> blk_shift;
      cnt_left    = has_block ? (cnt8 - CNT_BITS'(BLOCK_BITS)) : cnt8;
      has_flush   = req_last_byte & (cnt_left != '0);
      pair_shift  = 4'(CNT_BITS'(BLOCK_BITS) - cnt_left);
      pair_value  = buf_new[BLOCK_BITS-1:0] << pair_shift;
      short_shift = 3'(CNT_BITS'(SHORT_BITS) - cnt_left);
      short_value = buf_new[SHORT_BITS-1:0] << short_shift;

      block_job.kind           = JOB_PAIR;
      block_job.value          = blk_shifted[BLOCK_BITS-1:0];
      block_job.end_of_run     = ~has_flush;
      block_job.end_of_message = ~has_flush & req_last_byte;

      flush_job.end_of_run     = 1'b1;
      flush_job.end_of_message = 1'b1;
      if (cnt_left < CNT_BITS'(7)) begin
         flush_job.kind  = JOB_SINGLE;
         flush_job.value = BLOCK_BITS'(sym_code(CHAR_BITS'(short_value)));
      end else begin
         flush_job.kind  = JOB_PAIR;
         flush_job.value = pair_value;
      end

      if (req_empty_message) begin
         first_job.kind           = JOB_SINGLE;
         first_job.value          = BLOCK_BITS'(TILDE_CHAR);
         first_job.end_of_run     = 1'b1;
         first_job.end_of_message = 1'b1;
      end else if (has_block) begin
         first_job = block_job;
      end else begin
         first_job = flush_job;
      end
   end

   // drive the queue: the pending second job goes first when held
   always_comb begin
      if (pend_valid_ff) begin
         job_push = ~job_full;
         job_data = pend_job_ff;
      end else begin
         job_push = accept & (req_empty_message | has_block | has_flush);
         job_data = first_job;
      end
   end

   // advance the bit buffer and hold a second job if the item made two
   always_comb begin
      buffer_in     = buffer_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_job_in   = pend_job_ff;
      if (pend_valid_ff && !job_full) begin
         pend_valid_in = 1'b0;
      end
      if (accept) begin
         if (req_empty_message || req_last_byte) begin
            buffer_in = '0;
            count_in  = '0;
         end else begin
            buffer_in = buf_new;
            count_in  = cnt_left;
         end
         if (!req_empty_message && has_block && has_flush) begin
            pend_valid_in = 1'b1;
            pend_job_in   = flush_job;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff     <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         buffer_ff     <= buffer_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_job_ff <= pend_job_in;
   end

   // pending bits never reach a full block between items
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(12))
      else $error("bit count above 12 between items");

   // a second job is only held after a flush that followed a block
   a_pend_is_flush : assert property (@(posedge clock) disable iff (reset)
      $rose(pend_valid_ff) |-> pend_job_ff.end_of_message && $past(req_last_byte))
      else $error("pending job without a last byte");

endmodule

`default_nettype wire

/* rtl/bse_queue.sv */
// ----------------------------------------------------------------------------
// bse_queue
// Short job queue that decouples the byte front end from the character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_queue import bse_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_push,
   input  job_type       in_job,
   output logic          in_full,
   input  wire logic     out_pop,
   output job_type       out_job,
   output logic          out_empty
);

   job_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   fill_ff, fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign in_full   = fill_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign out_empty = fill_ff == '0;
   assign out_job   = slot_ff[rd_ptr_ff];
   assign do_push   = in_push & ~in_full;
   assign do_pop    = out_pop & ~out_empty;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QUEUE_CW'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

   // pointers stay in step with the fill level
   a_ptr_fill : assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == QUEUE_CW'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step");

   // the front end never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(in_push && in_full))
      else $error("push into full job queue");

endmodule

`default_nettype wire

/* rtl/bse_back.sv */
// ----------------------------------------------------------------------------
// bse_back
// Splits each block into quotient and remainder by 91, maps them to
// characters, passes single-character jobs through and feeds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_back import bse_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_empty,
   input  job_type                    job_data,
   output logic                       job_pop,
   output logic                       empty,
   input  wire logic                  pop,
   output logic [CHAR_BITS-1:0]       rsp_out_char,
   output logic                       rsp_end_of_run,
   output logic                       rsp_end_of_message
);

   // work stage
   logic                  stg_valid_ff, stg_valid_in;
   job_type               stg_job_ff, stg_job_in;
   logic [QUOT_BITS-1:0]  stg_quot_ff, stg_quot_in;
   phase_type             stg_phase_ff, stg_phase_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_eor_ff, rsp_eor_in;
   logic                  rsp_eom_ff, rsp_eom_in;

   logic [PROD_BITS-1:0]  quot_prod;
   logic [BLOCK_BITS-1:0] quot_times;
   logic [BLOCK_BITS-1:0] remainder;
   logic [CHAR_BITS-1:0]  stg_char;
   logic                  stg_last;
   logic                  out_load;
   logic                  stage_done;

   // quotient by reciprocal multiply of the incoming block
   assign quot_prod = PROD_BITS'(job_data.value) * PROD_BITS'(RECIP);

   // remainder from the registered quotient
   assign quot_times = BLOCK_BITS'(stg_quot_ff) * BLOCK_BITS'(RADIX);
   assign remainder  = stg_job_ff.value - quot_times;

   // pick the character the stage offers this cycle
   always_comb begin
      if (stg_job_ff.kind == JOB_SINGLE) begin
         stg_char = stg_job_ff.value[CHAR_BITS-1:0];
         stg_last = 1'b1;
      end else if (stg_phase_ff == PH_HIGH) begin
         stg_char = sym_code(stg_quot_ff);
         stg_last = 1'b0;
      end else begin
         stg_char = sym_code(remainder[CHAR_BITS-1:0]);
         stg_last = 1'b1;
      end
   end

   assign empty      = ~rsp_valid_ff;
   assign out_load   = stg_valid_ff & (~rsp_valid_ff | pop);
   assign stage_done = out_load & stg_last;
   assign job_pop    = ~job_empty & (~stg_valid_ff | stage_done);

   // next state of the stage and the result register
   always_comb begin
      stg_valid_in = stg_valid_ff;
      stg_job_in   = stg_job_ff;
      stg_quot_in  = stg_quot_ff;
      stg_phase_in = stg_phase_ff;
      if (job_pop) begin
         stg_valid_in = 1'b1;
         stg_job_in   = job_data;
         stg_quot_in  = quot_prod[RECIP_SHIFT +: QUOT_BITS];
         stg_phase_in = PH_HIGH;
      end else if (stage_done) begin
         stg_valid_in = 1'b0;
      end else if (out_load) begin
         stg_phase_in = PH_LOW;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_eor_in   = rsp_eor_ff;
      rsp_eom_in   = rsp_eom_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = stg_char;
         rsp_eor_in   = stg_last & stg_job_ff.end_of_run;
         rsp_eom_in   = stg_last & stg_job_ff.end_of_message;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         stg_phase_ff <= PH_HIGH;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         stg_phase_ff <= stg_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stg_job_ff  <= stg_job_in;
      stg_quot_ff <= stg_quot_in;
      rsp_char_ff <= rsp_char_in;
      rsp_eor_ff  <= rsp_eor_in;
      rsp_eom_ff  <= rsp_eom_in;
   end

   assign rsp_out_char       = rsp_char_ff;
   assign rsp_end_of_run     = rsp_eor_ff;
   assign rsp_end_of_message = rsp_eom_ff;

   // only a block job has a second character
   a_low_is_pair : assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && stg_phase_ff == PH_LOW) |-> stg_job_ff.kind == JOB_PAIR)
      else $error("second character phase on a single job");

   // the quotient of a 13-bit block stays a valid symbol index
   a_quot_range : assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && stg_job_ff.kind == JOB_PAIR) |-> stg_quot_ff < QUOT_BITS'(RADIX))
      else $error("quotient out of range");

endmodule

`default_nettype wire

/* rtl/base92_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base92_stream_encoder
// Streaming Base92 encoder: bytes in, printable characters out.
//
//   channel   ports                                         handshake
//   input     req_data_byte, req_last_byte,                 push / full
//             req_empty_message
//   result    rsp_out_char, rsp_end_of_run,                 empty / pop
//             rsp_end_of_message
//
// A byte is taken whenever push is high and full is low; an item that yields
// a block and a flush holds full while its second job enters the queue.
// The back end issues one character per cycle while pop keeps the single result
// register free. A character passes the queue, the work stage and that register
// on its way from an accepted byte to the result ports.
// Synchronous reset clears the bit buffer, the queue and all valid flags.
// A stall on pop backs up through the queue to full; neither side drops beats.
// ----------------------------------------------------------------------------
`default_nettype none

module base92_stream_encoder import bse_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   input  wire logic                 req_empty_message,
   output logic                      empty,
   input  wire logic                 pop,
   output logic [CHAR_BITS-1:0]      rsp_out_char,
   output logic                      rsp_end_of_run,
   output logic                      rsp_end_of_message
);

   logic     fq_push;
   job_type  fq_job;
   logic     fq_full;
   logic     qb_pop;
   job_type  qb_job;
   logic     qb_empty;

   // classify bytes into jobs
   bse_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_empty_message (req_empty_message),
      .job_push          (fq_push),
      .job_data          (fq_job),
      .job_full          (fq_full)
   );

   // decouple front and back
   bse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (fq_push),
      .in_job    (fq_job),
      .in_full   (fq_full),
      .out_pop   (qb_pop),
      .out_job   (qb_job),
      .out_empty (qb_empty)
   );

   // turn jobs into characters
   bse_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_empty          (qb_empty),
      .job_data           (qb_job),
      .job_pop            (qb_pop),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_char       (rsp_out_char),
      .rsp_end_of_run     (rsp_end_of_run),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Base92 stream encoder. Byte messages go in
// through the push/full queue port; every character that comes out through
// empty/pop is compared against a bit-accurate encoder model kept here.
// ----------------------------------------------------------------------------

module tb_top;
   import bse_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RX_HOLD_CYCLES = 200;
   localparam int DRAIN_TAIL     = 8;
   localparam int RANDOM_ITEMS   = 56;
   localparam int REPORT_MAX     = 10;

   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic                 eor;
      logic                 eom;
   } enc_char_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic [7:0]           req_data_byte = 8'h00;
   logic                 req_last_byte = 1'b0;
   logic                 req_empty_message = 1'b0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [CHAR_BITS-1:0] rsp_out_char;
   logic                 rsp_end_of_run;
   logic                 rsp_end_of_message;

   // encoder model state and the characters it still owes
   logic [19:0]          enc_bits = '0;
   logic [4:0]           enc_count = '0;
   enc_char_t            exp_chars[$];

   int                   err_count = 0;
   int                   cycle_count = 0;
   int                   items_sent = 0;
   int                   rx_stall_left = 0;
   bit                   tx_idle_on = 1'b1;
   bit                   rx_idle_on = 1'b1;
   bit                   rx_hold_go = 1'b0;
   logic                 rx_holding = 1'b0;

   base92_stream_encoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_empty_message  (req_empty_message),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_char       (rsp_out_char),
      .rsp_end_of_run     (rsp_end_of_run),
      .rsp_end_of_message (rsp_end_of_message)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // encoder model
   // ---------------------------------------------------------------------

   // map a symbol index 0..90 onto the alphabet, skipping quote and backtick
   function automatic logic [CHAR_BITS-1:0] b92_symbol(input int unsigned v);
      if (v == 0) begin
         return 7'd33;
      end else if (v < 62) begin
         return CHAR_BITS'(v + 34);
      end
      return CHAR_BITS'(v + 35);
   endfunction

   function automatic void push_char(input logic [CHAR_BITS-1:0] ch);
      enc_char_t c;
      c.ch  = ch;
      c.eor = 1'b0;
      c.eom = 1'b0;
      exp_chars.push_back(c);
   endfunction

   // a 13-bit block gives quotient then remainder by the radix
   function automatic void push_block(input int unsigned v);
      int unsigned blk;
      blk = v & 32'h1FFF;
      push_char(b92_symbol(blk / RADIX));
      push_char(b92_symbol(blk % RADIX));
   endfunction

   function automatic void encode_item(input logic [7:0] d, input logic l, input logic e);
      int unsigned n_before;
      int unsigned v;
      n_before = exp_chars.size();
      if (e) begin
         // empty message: one tilde, drop anything pending
         push_char(TILDE_CHAR);
         enc_bits  = '0;
         enc_count = '0;
      end else begin
         enc_bits  = {enc_bits[11:0], d};
         enc_count = enc_count + 5'd8;
         if (enc_count >= 13) begin
            v = 32'(enc_bits) >> (enc_count - 13);
            push_block(v);
            enc_count = enc_count - 5'd13;
         end
         // flush leftover bits on the final byte
         if (l) begin
            if (enc_count > 0 && enc_count < 7) begin
               v = (32'(enc_bits) << (6 - enc_count)) & 32'h3F;
               push_char(b92_symbol(v));
            end else if (enc_count >= 7) begin
               push_block(32'(enc_bits) << (13 - enc_count));
            end
            enc_bits  = '0;
            enc_count = '0;
         end
      end
      // flag the last character of this item and of the message
      if (exp_chars.size() > n_before) begin
         exp_chars[$].eor = 1'b1;
         if (l || e) begin
            exp_chars[$].eom = 1'b1;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------

   // offer one beat; enters and leaves on a rising edge
   task automatic send_byte(input logic [7:0] d, input logic l, input logic e);
      int gap;
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push              <= 1'b1;
      req_data_byte     <= d;
      req_last_byte     <= l;
      req_empty_message <= e;
      do begin
         @(posedge clock);
      end while (full);
      encode_item(d, l, e);
      items_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // a well-formed message; length zero is sent as an empty-message item
   task automatic send_message(input int len);
      if (len == 0) begin
         send_byte(8'($urandom), 1'($urandom), 1'b1);
      end else begin
         for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), i == len - 1, 1'b0);
         end
      end
   endtask

   // drop push and wait until every owed character is out
   task automatic wait_drained();
      push <= 1'b0;
      while (exp_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver and result check
   // ---------------------------------------------------------------------

   // stall pop in random bursts, or for a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         rx_stall_left <= 0;
      end else if (rx_holding) begin
         pop <= 1'b0;
      end else if (rx_stall_left != 0) begin
         pop <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
         pop <= 1'b0;
         rx_stall_left <= $urandom_range(0, 18);
      end else begin
         pop <= 1'b1;
      end
   end

   // long receiver hold, counted here
   initial begin
      forever begin
         wait (rx_hold_go);
         @(posedge clock);
         rx_holding <= 1'b1;
         repeat (RX_HOLD_CYCLES) @(posedge clock);
         rx_holding <= 1'b0;
         rx_hold_go = 1'b0;
      end
   end

   // compare each accepted beat with the oldest expected character
   always @(posedge clock) begin
      enc_char_t want;
      if (!reset && pop && !empty) begin
         if (exp_chars.size() == 0) begin
            if (err_count < REPORT_MAX) begin
               $display("unexpected char: got ch=%0d eor=%0b eom=%0b",
                        rsp_out_char, rsp_end_of_run, rsp_end_of_message);
            end
            err_count++;
         end else begin
            want = exp_chars.pop_front();
            if (rsp_out_char !== want.ch || rsp_end_of_run !== want.eor ||
                rsp_end_of_message !== want.eom) begin
               if (err_count < REPORT_MAX) begin
                  $display("char mismatch: exp ch=%0d eor=%0b eom=%0b, got ch=%0d eor=%0b eom=%0b",
                           want.ch, want.eor, want.eom,
                           rsp_out_char, rsp_end_of_run, rsp_end_of_message);
               end
               err_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // field extremes, every flush length class and the empty message
   task automatic test_directed_edges();
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b0);
      // nine bytes: the last one gives a block plus a two-char flush
      for (int i = 0; i < 9; i++) begin
         send_byte(8'hFF, i == 8, 1'b0);
      end
      // five bytes: block plus a one-char flush of a single bit
      for (int i = 0; i < 5; i++) begin
         send_byte(i[0] ? 8'hAA : 8'h55, i == 4, 1'b0);
      end
      // empty message drops a half-built message
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'h3C, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b0);
   endtask

   task automatic test_random_messages();
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               // lone empty-message item with junk fields
               send_byte(8'($urandom), 1'($urandom), 1'b1);
            end
            1: begin
               // broken message cut short by an empty-message item
               send_message(0);
               for (int i = $urandom_range(1, 5); i > 0; i--) begin
                  send_byte(pick_byte(), 1'b0, 1'b0);
               end
               send_byte(8'($urandom), 1'($urandom), 1'b1);
            end
            default: begin
               send_message($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 14));
            end
         endcase
      end
   endtask

   // hold the receiver off while the sender keeps pushing
   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      rx_hold_go = 1'b1;
      send_message(24);
      send_message(9);
      tx_idle_on = 1'b1;
   endtask

   // sender pauses until every owed character has come out
   task automatic test_drain_pause();
      send_message(9);
      wait_drained();
      send_message(13);
      wait_drained();
      send_message(1);
   endtask

   task automatic test_steady_no_idle();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      for (int i = 0; i < 4; i++) begin
         send_message($urandom_range(1, 12));
      end
      send_message(0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_random_messages();
      test_backpressure();
      test_drain_pause();
      test_steady_no_idle();
      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (err_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
